### rtl/gbpb_pkg.sv
// package for the grid broad-phase binning block
// opcodes, register indexes, field widths and default sizes; no dependencies
package gbpb_pkg;

    localparam int CELL_PIXELS_DEF = 32;
    localparam int GRID_COLS_DEF   = 32;
    localparam int GRID_ROWS_DEF   = 32;
    localparam int SHAPE_COUNT_DEF = 64;

    localparam int OP_W     = 2;
    localparam int ID_W     = 6;
    localparam int COORD_W  = 16;
    localparam int LEN_W    = 15;
    localparam int SCREEN_W = 11;
    localparam int CFG_IDX_W = 1;

    // quotient width covers every magnitude that goes through the divider
    localparam int Q_W = 16;

    localparam logic [SCREEN_W-1:0] SCREEN_RESET = SCREEN_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic           empty;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
    } t_span;

endpackage

### rtl/gbpb_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module gbpb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/grid_broad_phase_binning.sv
// top level of the grid broad-phase binning block
// uses gbpb_pkg and one gbpb_ram instance holding the per-cell id bitmaps
//
// The cell bitmaps live in one ram of GRID_ROWS*GRID_COLS words, SHAPE_COUNT bits wide.
// After reset, and after every clear item, a clearing pass writes zero to one cell per
// cycle over all GRID_ROWS*GRID_COLS cells, while no item is taken (configuration writes
// are taken as ever). An insert or query item first runs its box corners and the screen
// size through a three-stage constant divider (6 operands), works out the cell range and
// walks the covered cells at one ram read per cycle (inserts write each cell back the
// cycle after its read). A query then gives one result per cycle while the output side
// takes them, in ascending id order, or one empty result. A new item is taken only when
// the previous one is done; a last result may still wait.
module grid_broad_phase_binning #(
    parameter int CELL_PIXELS = gbpb_pkg::CELL_PIXELS_DEF,
    parameter int GRID_COLS   = gbpb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS   = gbpb_pkg::GRID_ROWS_DEF,
    parameter int SHAPE_COUNT = gbpb_pkg::SHAPE_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbpb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbpb_pkg::SCREEN_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gbpb_pkg::OP_W-1:0]         i_opcode,
    input  logic [gbpb_pkg::ID_W-1:0]         i_shape_id,
    input  logic signed [gbpb_pkg::COORD_W-1:0] i_box_left,
    input  logic signed [gbpb_pkg::COORD_W-1:0] i_box_top,
    input  logic [gbpb_pkg::LEN_W-1:0]        i_box_width,
    input  logic [gbpb_pkg::LEN_W-1:0]        i_box_height,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [gbpb_pkg::ID_W-1:0]         o_found_id,
    output logic                              o_found_valid,
    output logic                              o_last
);

    localparam int Q_W     = gbpb_pkg::Q_W;
    localparam int ID_W    = gbpb_pkg::ID_W;
    localparam int CELLS   = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int DIV_SH  = Q_W + 1;
    localparam int RECIP   = (1 << DIV_SH) / CELL_PIXELS;
    localparam int RECIP_W = DIV_SH + 1;
    localparam int P_W     = Q_W + RECIP_W;
    localparam int CP_W    = $clog2(CELL_PIXELS + 1);
    localparam int PR_W    = Q_W + CP_W;
    localparam int DIV_OPS = 6;
    localparam int TAG_W   = 3;
    localparam int DCNT_W  = 4;
    localparam int DIV_LAST = DIV_OPS + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_SPAN, S_BASE, S_WALK, S_DRAIN, S_EMIT
    } t_state;

    t_state r_state;

    logic [gbpb_pkg::SCREEN_W-1:0] r_screen_w, r_screen_h;

    // item registers
    gbpb_pkg::t_opcode r_op;
    logic [ID_W-1:0]   r_id;
    logic [Q_W-2:0]    r_sx_mag, r_sy_mag;
    logic [Q_W-1:0]    r_ex_mag, r_ey_mag;
    logic              r_ex_neg, r_ey_neg;

    // divider pipeline
    logic [DCNT_W-1:0] r_div_cnt;
    logic [Q_W-1:0]    div_m;
    logic              r_v1, r_v2;
    logic [TAG_W-1:0]  r_tag1, r_tag2;
    logic [P_W-1:0]    r_p1;
    logic [Q_W-1:0]    r_m1, r_m2, r_q2;
    logic [PR_W-1:0]   r_prod;
    logic [PR_W-1:0]   div_rem;
    logic [Q_W-1:0]    div_q;
    logic [Q_W-1:0]    r_q [DIV_OPS];

    // cell range and walk
    logic [COL_W-1:0]  r_c0, r_c1, r_col;
    logic [ROW_W-1:0]  r_r0, r_r1, r_row;
    logic [ADDR_W-1:0] r_row_base, r_clr_addr, r_rd_addr;
    logic              r_rd_pend;
    logic [SHAPE_COUNT-1:0] r_hits;

    // output register
    logic              r_out_valid;
    logic [ID_W-1:0]   r_found_id;
    logic              r_found_valid, r_last;

    logic [Q_W:0]      end_x, end_y;
    logic [Q_W-1:0]    used_c, used_r;
    gbpb_pkg::t_span   span_c, span_r;
    logic              in_acc, out_load, id_ok;
    logic [SHAPE_COUNT-1:0] low_bit, rest_hits, id_bit;
    logic [ID_W-1:0]   enc_id;

    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [SHAPE_COUNT-1:0] ram_wdata, ram_rdata;

    function automatic gbpb_pkg::t_span axis_span(
        input logic [Q_W-1:0] q_lo,
        input logic           end_neg,
        input logic [Q_W-1:0] q_hi,
        input logic [Q_W-1:0] used
    );
        gbpb_pkg::t_span s;
        logic [Q_W-1:0]  hi_lim;
        logic [Q_W-1:0]  hi;
        hi_lim = used - Q_W'(1);
        hi = end_neg ? '0 : q_hi;
        if (hi > hi_lim) begin
            hi = hi_lim;
        end
        s.lo = q_lo;
        s.hi = hi;
        s.empty = (used == '0) || (end_neg && (q_hi != '0)) || (q_lo > hi);
        return s;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign id_ok      = ({1'b0, i_shape_id} < (ID_W + 1)'(SHAPE_COUNT));

    assign end_x = {i_box_left[Q_W-1], i_box_left} + {2'b00, i_box_width};
    assign end_y = {i_box_top[Q_W-1], i_box_top} + {2'b00, i_box_height};

    // divider operand select
    always_comb begin
        case (r_div_cnt)
            DCNT_W'(0): div_m = {1'b0, r_sx_mag};
            DCNT_W'(1): div_m = r_ex_mag;
            DCNT_W'(2): div_m = {1'b0, r_sy_mag};
            DCNT_W'(3): div_m = r_ey_mag;
            DCNT_W'(4): div_m = Q_W'(r_screen_w);
            DCNT_W'(5): div_m = Q_W'(r_screen_h);
            default:    div_m = '0;
        endcase
    end

    assign div_rem = PR_W'(r_m2) - r_prod;
    assign div_q   = r_q2 + Q_W'(div_rem >= PR_W'(CELL_PIXELS));

    // quotient by reciprocal, low by at most one, then one correcting compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1   <= (r_state == S_DIV) && (r_div_cnt < DCNT_W'(DIV_OPS));
            r_tag1 <= r_div_cnt[TAG_W-1:0];
            r_p1   <= P_W'(div_m) * P_W'(RECIP);
            r_m1   <= div_m;
            r_v2   <= r_v1;
            r_tag2 <= r_tag1;
            r_q2   <= r_p1[DIV_SH +: Q_W];
            r_prod <= PR_W'(r_p1[DIV_SH +: Q_W]) * PR_W'(CELL_PIXELS);
            r_m2   <= r_m1;
            if (r_v2) begin
                r_q[r_tag2] <= div_q;
            end
        end
    end

    assign used_c = (r_q[4] > Q_W'(GRID_COLS)) ? Q_W'(GRID_COLS) : r_q[4];
    assign used_r = (r_q[5] > Q_W'(GRID_ROWS)) ? Q_W'(GRID_ROWS) : r_q[5];
    assign span_c = axis_span(r_q[0], r_ex_neg, r_q[1], used_c);
    assign span_r = axis_span(r_q[2], r_ey_neg, r_q[3], used_r);

    // lowest set id of the remaining hits
    assign low_bit   = r_hits & (~r_hits + SHAPE_COUNT'(1));
    assign rest_hits = r_hits & ~low_bit;
    always_comb begin
        enc_id = '0;
        for (int i = 0; i < SHAPE_COUNT; i++) begin
            if (low_bit[i]) begin
                enc_id = enc_id | ID_W'(i);
            end
        end
    end

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    assign id_bit    = SHAPE_COUNT'(1) << r_id;
    assign ram_re    = (r_state == S_WALK);
    assign ram_raddr = r_row_base + ADDR_W'(r_col);

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_rd_pend && (r_op == gbpb_pkg::OP_INSERT);
            ram_waddr = r_rd_addr;
            ram_wdata = ram_rdata | id_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_div_cnt   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_screen_w  <= gbpb_pkg::SCREEN_RESET;
            r_screen_h  <= gbpb_pkg::SCREEN_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gbpb_pkg::CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                    gbpb_pkg::CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                    default: ;
                endcase
            end

            r_rd_pend <= ram_re;
            r_rd_addr <= ram_raddr;
            if (r_rd_pend && (r_op == gbpb_pkg::OP_QUERY)) begin
                r_hits <= r_hits | ram_rdata;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op       <= gbpb_pkg::t_opcode'(i_opcode);
                        r_id       <= i_shape_id;
                        r_sx_mag   <= i_box_left[Q_W-1] ? '0 : i_box_left[Q_W-2:0];
                        r_sy_mag   <= i_box_top[Q_W-1] ? '0 : i_box_top[Q_W-2:0];
                        r_ex_neg   <= end_x[Q_W];
                        r_ey_neg   <= end_y[Q_W];
                        r_ex_mag   <= end_x[Q_W] ? Q_W'(~end_x + 1'b1) : end_x[Q_W-1:0];
                        r_ey_mag   <= end_y[Q_W] ? Q_W'(~end_y + 1'b1) : end_y[Q_W-1:0];
                        r_hits     <= '0;
                        r_div_cnt  <= '0;
                        r_clr_addr <= '0;
                        case (gbpb_pkg::t_opcode'(i_opcode))
                            gbpb_pkg::OP_CLEAR:  r_state <= S_CLEAR;
                            gbpb_pkg::OP_INSERT: r_state <= id_ok ? S_DIV : S_IDLE;
                            gbpb_pkg::OP_QUERY:  r_state <= S_DIV;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + DCNT_W'(1);
                    if (r_div_cnt == DCNT_W'(DIV_LAST)) begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_c0 <= span_c.lo[COL_W-1:0];
                    r_c1 <= span_c.hi[COL_W-1:0];
                    r_r0 <= span_r.lo[ROW_W-1:0];
                    r_r1 <= span_r.hi[ROW_W-1:0];
                    if (span_c.empty || span_r.empty) begin
                        r_state <= (r_op == gbpb_pkg::OP_QUERY) ? S_EMIT : S_IDLE;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_row_base <= ADDR_W'(ADDR_W'(r_r0) * ADDR_W'(GRID_COLS));
                    r_row      <= r_r0;
                    r_col      <= r_c0;
                    r_state    <= S_WALK;
                end
                S_WALK: begin
                    if (r_col == r_c1) begin
                        r_col <= r_c0;
                        if (r_row == r_r1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_row      <= r_row + ROW_W'(1);
                            r_row_base <= r_row_base + ADDR_W'(GRID_COLS);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= (r_op == gbpb_pkg::OP_QUERY) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_load) begin
                        if (r_hits == '0) begin
                            r_found_id    <= '0;
                            r_found_valid <= 1'b0;
                            r_last        <= 1'b1;
                            r_state       <= S_IDLE;
                        end else begin
                            r_found_id    <= enc_id;
                            r_found_valid <= 1'b1;
                            r_last        <= (rest_hits == '0);
                            r_hits        <= rest_hits;
                            if (rest_hits == '0) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gbpb_ram #(
        .WIDTH (SHAPE_COUNT),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_found_id    = r_found_id;
    assign o_found_valid = r_found_valid;
    assign o_last        = r_last;

    // the walk never reads back the cell whose write-back is pending
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && ram_re) |-> (ram_raddr != r_rd_addr))
        else $error("cell read overlaps pending write-back");

    // no read is in flight while the clearing pass owns the write port
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_rd_pend)
        else $error("read pending during clearing pass");

    // walk stays inside the computed range
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_col <= r_c1) && (r_row <= r_r1) && (r_col >= r_c0)))
        else $error("walk left its cell range");

    // a final result hands control back to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && ((r_hits == '0) || (rest_hits == '0))) |=>
        ((r_state == S_IDLE) && r_out_valid && r_last))
        else $error("final result did not end the query");

endmodule

### test/tb_grid_broad_phase_binning.sv
`timescale 1ns / 1ps
// testbench for grid_broad_phase_binning: directed and random clear, insert and query items,
// each query result checked against an in-bench copy of the cell bitmaps; needs gbpb_pkg and the rtl
module tb_grid_broad_phase_binning;

    localparam int CELL          = gbpb_pkg::CELL_PIXELS_DEF;
    localparam int COLS          = gbpb_pkg::GRID_COLS_DEF;
    localparam int ROWS          = gbpb_pkg::GRID_ROWS_DEF;
    localparam int SHAPES        = gbpb_pkg::SHAPE_COUNT_DEF;
    localparam int ID_W          = gbpb_pkg::ID_W;
    localparam int COORD_W       = gbpb_pkg::COORD_W;
    localparam int LEN_W         = gbpb_pkg::LEN_W;
    localparam int SCREEN_W      = gbpb_pkg::SCREEN_W;
    localparam int SETTLE_CYCLES = 1200;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            hit;
        logic            last;
    } t_found;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} t_rx_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [gbpb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SCREEN_W-1:0]        i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [gbpb_pkg::OP_W-1:0]  i_opcode = '0;
    logic [ID_W-1:0]            i_shape_id = '0;
    logic signed [COORD_W-1:0]  i_box_left = '0;
    logic signed [COORD_W-1:0]  i_box_top = '0;
    logic [LEN_W-1:0]           i_box_width = '0;
    logic [LEN_W-1:0]           i_box_height = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [ID_W-1:0]            o_found_id;
    logic                       o_found_valid;
    logic                       o_last;

    logic [SHAPES-1:0]          cell_ids [ROWS*COLS];
    logic [SCREEN_W-1:0]        screen_w_px = gbpb_pkg::SCREEN_RESET;
    logic [SCREEN_W-1:0]        screen_h_px = gbpb_pkg::SCREEN_RESET;
    t_found                     found_due [$];
    int                         err_count = 0;
    int                         items_sent = 0;
    int                         results_seen = 0;
    int                         cfg_writes = 0;
    int                         burst_left = 0;
    int                         cycle_count = 0;
    t_rx_mode                   ready_mode = RX_OPEN;
    int                         ready_left = 0;

    grid_broad_phase_binning dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_shape_id    (i_shape_id),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found_id    (o_found_id),
        .o_found_valid (o_found_valid),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, switched at random between the open, light, heavy and pulse modes
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_rx_mode'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 160);
        end
        ready_left--;
        case (ready_mode)
            RX_OPEN:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:  i_out_ready <= ready_left[2];
        endcase
    end

    always @(posedge i_clk) begin
        t_found want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (found_due.size() == 0) begin
                $error("result with no query waiting: found_id %0d", o_found_id);
                err_count++;
            end else begin
                want = found_due.pop_front();
                if (o_found_id !== want.id) begin
                    $error("found_id: expected %0d, got %0d", want.id, o_found_id);
                    err_count++;
                end
                if (o_found_valid !== want.hit) begin
                    $error("found_valid: expected %0d, got %0d", want.hit, o_found_valid);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    function automatic int cells_in_use(int px, int cap);
        return (px / CELL > cap) ? cap : px / CELL;
    endfunction

    function automatic bit cover_axis(int start, int len, int used, output int lo, output int hi);
        lo = start / CELL;
        hi = (start + len) / CELL;
        if (lo < 0) lo = 0;
        if (hi > used - 1) hi = used - 1;
        return lo <= hi;
    endfunction

    // apply one accepted item to the bitmaps and queue the ids a query should report
    task automatic update_cells(gbpb_pkg::t_opcode op, logic [ID_W-1:0] id,
                                logic signed [COORD_W-1:0] left, logic signed [COORD_W-1:0] top,
                                logic [LEN_W-1:0] w, logic [LEN_W-1:0] h);
        int c0, c1, r0, r1, r, c, n, k;
        bit span_x, span_y;
        logic [SHAPES-1:0] ids;
        t_found f;
        span_x = cover_axis(int'(left), int'(w), cells_in_use(screen_w_px, COLS), c0, c1);
        span_y = cover_axis(int'(top), int'(h), cells_in_use(screen_h_px, ROWS), r0, r1);
        ids = '0;
        case (op)
            gbpb_pkg::OP_CLEAR: begin
                foreach (cell_ids[i]) cell_ids[i] = '0;
            end
            gbpb_pkg::OP_INSERT: begin
                if (span_x && span_y && (int'(id) < SHAPES))
                    for (r = r0; r <= r1; r++)
                        for (c = c0; c <= c1; c++)
                            cell_ids[r*COLS + c][id] = 1'b1;
            end
            gbpb_pkg::OP_QUERY: begin
                if (span_x && span_y)
                    for (r = r0; r <= r1; r++)
                        for (c = c0; c <= c1; c++)
                            ids |= cell_ids[r*COLS + c];
                n = $countones(ids);
                if (n == 0) begin
                    f = '{id: '0, hit: 1'b0, last: 1'b1};
                    found_due.push_back(f);
                end else begin
                    k = 0;
                    for (int i = 0; i < SHAPES; i++) begin
                        if (ids[i]) begin
                            k++;
                            f = '{id: ID_W'(i), hit: 1'b1, last: (k == n)};
                            found_due.push_back(f);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // called and returns at a falling edge; valid is only lowered when a gap is taken
    task automatic send_item(gbpb_pkg::t_opcode op, logic [ID_W-1:0] id,
                             logic signed [COORD_W-1:0] left, logic signed [COORD_W-1:0] top,
                             logic [LEN_W-1:0] w, logic [LEN_W-1:0] h);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_shape_id   <= id;
        i_box_left   <= left;
        i_box_top    <= top;
        i_box_width  <= w;
        i_box_height <= h;
        do @(posedge i_clk); while (!o_in_ready);
        update_cells(op, id, left, top, w, h);
        items_sent++;
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (found_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_screen(logic [SCREEN_W-1:0] w_px, logic [SCREEN_W-1:0] h_px);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gbpb_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data  <= w_px;
        @(negedge i_clk);
        i_cfg_index <= gbpb_pkg::CFG_SCREEN_HEIGHT;
        i_cfg_data  <= h_px;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        screen_w_px = w_px;
        screen_h_px = h_px;
        cfg_writes += 2;
        @(negedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16) return LEN_W'($urandom_range(0, 80));
        if (r < 19) return LEN_W'($urandom_range(0, 1100));
        return LEN_W'($urandom);
    endfunction

    task automatic test_empty_after_reset();
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
    endtask

    task automatic test_cell_corners();
        send_item(gbpb_pkg::OP_INSERT, 6'd0, 16'sd0, 16'sd0, 15'd0, 15'd0);
        send_item(gbpb_pkg::OP_INSERT, 6'd63, 16'sd1023, 16'sd1023, 15'd0, 15'd0);
        // most negative corner with the widest box ends at -1, which lands in cell zero
        send_item(gbpb_pkg::OP_INSERT, 6'd31, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
        // box starting beyond the grid is empty
        send_item(gbpb_pkg::OP_INSERT, 6'd5, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd31, 15'd31);
        send_item(gbpb_pkg::OP_QUERY, 6'd63, 16'sd0, 16'sd0, 15'd32767, 15'd32767);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd1000, 16'sd1000, 15'd10, 15'd10);
    endtask

    task automatic test_ignored_items();
        send_item(gbpb_pkg::OP_NONE, 6'd7, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
        // box left of the screen truncates to an empty column range
        send_item(gbpb_pkg::OP_INSERT, 6'd9, -16'sd100, 16'sd0, 15'd50, 15'd50);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
    endtask

    task automatic test_clear();
        send_item(gbpb_pkg::OP_INSERT, 6'd12, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
        send_item(gbpb_pkg::OP_CLEAR, 6'd0, 16'sd0, 16'sd0, 15'd0, 15'd0);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
        send_item(gbpb_pkg::OP_INSERT, 6'd12, 16'sd500, 16'sd500, 15'd100, 15'd100);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd480, 16'sd480, 15'd0, 15'd0);
    endtask

    task automatic test_screen_sizes();
        settle();
        set_screen(11'd0, 11'd1024);
        send_item(gbpb_pkg::OP_INSERT, 6'd20, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd1023, 15'd1023);
        settle();
        set_screen(11'd31, 11'd2047);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd32767, 15'd32767);
        settle();
        // oversized screen saturates at the grid size
        set_screen(11'd2047, 11'd2047);
        send_item(gbpb_pkg::OP_INSERT, 6'd21, 16'sd1000, 16'sd1000, 15'd2000, 15'd2000);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd1023, 16'sd1023, 15'd0, 15'd0);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd32767, 15'd32767);
        settle();
        set_screen(11'd100, 11'd64);
        send_item(gbpb_pkg::OP_INSERT, 6'd22, 16'sd90, 16'sd60, 15'd500, 15'd500);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd64, 16'sd32, 15'd0, 15'd0);
        send_item(gbpb_pkg::OP_QUERY, 6'd0, 16'sd0, 16'sd0, 15'd32767, 15'd32767);
    endtask

    task automatic random_items(int count);
        int roll;
        gbpb_pkg::t_opcode op;
        logic [ID_W-1:0] id;
        logic signed [COORD_W-1:0] left, top;
        logic [LEN_W-1:0] w, h;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            id   = ID_W'($urandom);
            left = COORD_W'(int'($urandom_range(0, screen_w_px + 64)) - 32);
            top  = COORD_W'(int'($urandom_range(0, screen_h_px + 64)) - 32);
            w    = pick_len();
            h    = pick_len();
            if (roll < 4) op = gbpb_pkg::OP_CLEAR;
            else if (roll < 48) op = gbpb_pkg::OP_INSERT;
            else if (roll < 88) op = gbpb_pkg::OP_QUERY;
            else if (roll < 92) op = gbpb_pkg::OP_NONE;
            else begin
                // noise over the whole field ranges
                op   = gbpb_pkg::t_opcode'($urandom_range(0, 3));
                left = COORD_W'($urandom);
                top  = COORD_W'($urandom);
                w    = LEN_W'($urandom);
                h    = LEN_W'($urandom);
            end
            send_item(op, id, left, top, w, h);
        end
    endtask

    task automatic test_random_traffic();
        settle();
        set_screen(11'd1024, 11'd1024);
        random_items(30);
        settle();
        set_screen(SCREEN_W'($urandom_range(32, 1024)), SCREEN_W'($urandom_range(32, 1024)));
        random_items(25);
        settle();
        set_screen(11'd2047, SCREEN_W'($urandom_range(0, 2047)));
        random_items(30);
    endtask

    initial begin
        foreach (cell_ids[i]) cell_ids[i] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_after_reset();
        test_cell_corners();
        test_ignored_items();
        test_clear();
        test_screen_sizes();
        test_random_traffic();
        settle();
        $display("ran %0d items through %0d screen register writes", items_sent, cfg_writes);
        $display("checked %0d query results, %0d mismatches", results_seen, err_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/gbpb_pkg.sv
rtl/gbpb_ram.sv
rtl/grid_broad_phase_binning.sv
test/tb_grid_broad_phase_binning.sv
